// ===== rtl/usvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usvt_pkg: shared definitions for the unique value set table
// Command and status codes, sizing constants and the cell control bundle.
// ----------------------------------------------------------------------------
package usvt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 64;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 3;
  localparam int POSITION_W   = 4;
  localparam int OCCUPANCY_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STS_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] STS_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STS_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_ABSENT    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND  = 3'd5;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd6;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic in_use;
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== rtl/usvt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usvt_cell: one entry of the key table
// Holds one key, registers its compare result against an incoming key, and
// either loads a new key or takes the key of its upper neighbor.
// ----------------------------------------------------------------------------
module usvt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  usvt_pkg::cell_ctl_t          ctl,
  input  logic [usvt_pkg::KEY_W-1:0]   probe,
  input  logic [usvt_pkg::KEY_W-1:0]   fill,
  input  logic [usvt_pkg::KEY_W-1:0]   neighbor,
  output logic [usvt_pkg::KEY_W-1:0]   entry,
  output logic                         match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.capture) begin
      match <= ctl.in_use && (entry == probe);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= fill;
    end else if (ctl.shift) begin
      entry <= neighbor;
    end
  end

endmodule

// ===== rtl/unique_value_set_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_set_table_top: ordered set of distinct 64-bit keys
// Add, remove and look up keys in a row of cells; removal closes the gap by
// moving every later key one cell down.
//
//   Channel  Direction  Handshake             Beat fields
//   in       input      in_valid / in_stall   cmd, key
//   out      output     out_valid / out_stall status, position, occupancy
//
// Each beat is handled first in the accept cycle, in which every cell compares its
// key, and then in the execute state, which merges the match bits, updates the
// cells and loads the result register. Reset clears the count and the result
// valid flag; the keys themselves are not cleared. A stalled result holds the
// block in its execute state; a new input beat is taken once that state ends.
// ----------------------------------------------------------------------------
module unique_value_set_table_top #(
  parameter int CAPACITY = usvt_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [usvt_pkg::CMD_W-1:0]         cmd,
  input  logic [usvt_pkg::KEY_W-1:0]         key,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [usvt_pkg::STATUS_W-1:0]      status,
  output logic [usvt_pkg::POSITION_W-1:0]    position,
  output logic [usvt_pkg::OCCUPANCY_W-1:0]   occupancy
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  usvt_pkg::state_t              state;
  usvt_pkg::state_t              state_next;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  logic [usvt_pkg::CMD_W-1:0]    cmd_q;
  logic [usvt_pkg::KEY_W-1:0]    key_q;

  logic [CAPACITY-1:0]           match;
  logic [usvt_pkg::KEY_W-1:0]    entry [CAPACITY];
  usvt_pkg::cell_ctl_t           ctl [CAPACITY];

  logic                          accept;
  logic                          finish;
  logic                          hit;
  logic [IW-1:0]                 hit_pos;
  logic                          full;
  logic                          apply_add;
  logic                          apply_rem;
  logic [usvt_pkg::STATUS_W-1:0] status_next;
  logic [IW-1:0]                 pos_next;

  assign in_stall = (state == usvt_pkg::ST_EXEC);
  assign accept   = in_valid && !in_stall;
  assign finish   = (state == usvt_pkg::ST_EXEC) && (!out_valid || !out_stall);

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit = hit | match[i];
      if (match[i]) begin
        hit_pos = hit_pos | IW'(i);
      end
    end
  end

  assign full = (count >= CAP_COUNT);

  always_comb begin
    state_next  = state;
    count_next  = count;
    apply_add   = 1'b0;
    apply_rem   = 1'b0;
    status_next = usvt_pkg::STS_NOTFOUND;
    pos_next    = '0;
    unique case (state)
      usvt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = usvt_pkg::ST_EXEC;
        end
      end
      usvt_pkg::ST_EXEC: begin
        unique case (cmd_q)
          usvt_pkg::CMD_ADD: begin
            priority if (hit) begin
              status_next = usvt_pkg::STS_DUPLICATE;
              pos_next    = hit_pos;
            end else if (full) begin
              status_next = usvt_pkg::STS_FULL;
            end else begin
              status_next = usvt_pkg::STS_ADDED;
              pos_next    = IW'(count);
              apply_add   = finish;
              count_next  = count + CW'(1);
            end
          end
          usvt_pkg::CMD_REMOVE: begin
            if (hit) begin
              status_next = usvt_pkg::STS_REMOVED;
              pos_next    = hit_pos;
              apply_rem   = finish;
              count_next  = count - CW'(1);
            end else begin
              status_next = usvt_pkg::STS_ABSENT;
            end
          end
          default: begin
            if (hit) begin
              status_next = usvt_pkg::STS_FOUND;
              pos_next    = hit_pos;
            end else begin
              status_next = usvt_pkg::STS_NOTFOUND;
            end
          end
        endcase
        if (finish) begin
          state_next = usvt_pkg::ST_IDLE;
        end else begin
          count_next = count;
        end
      end
      default: begin
        state_next = usvt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= usvt_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      key_q <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status    <= status_next;
      position  <= usvt_pkg::POSITION_W'(pos_next);
      occupancy <= usvt_pkg::OCCUPANCY_W'(count_next);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IW-1:0] IDX      = IW'(i);
    localparam logic [CW-1:0] IDX_C    = CW'(i);
    localparam logic [CW-1:0] IDX_NEXT = CW'(i + 1);
    logic [usvt_pkg::KEY_W-1:0] neighbor;

    if (i == CAPACITY - 1) begin : g_last
      assign neighbor = entry[i];
    end else begin : g_mid
      assign neighbor = entry[i+1];
    end

    always_comb begin
      ctl[i].capture = accept;
      ctl[i].in_use  = (IDX_C < count);
      ctl[i].load    = apply_add && (IDX_C == count);
      ctl[i].shift   = apply_rem && (IDX >= hit_pos) && (IDX_NEXT < count);
    end

    usvt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[i]),
      .probe    (key),
      .fill     (key_q),
      .neighbor (neighbor),
      .entry    (entry[i]),
      .match    (match[i])
    );
  end

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == usvt_pkg::ST_EXEC) |-> $onehot0(match))
    else $error("more than one cell matched the key");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("entry count exceeds capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == usvt_pkg::ST_EXEC))
    else $error("accepted beat did not enter execution");

  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && (occupancy == usvt_pkg::OCCUPANCY_W'(count))))
    else $error("result beat missing or occupancy disagrees with count");

endmodule

// ===== sim/tb_unique_value_set_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unique_value_set_table_top: self-checking bench for the key set table
// A short scripted sequence walks the empty, full, duplicate, spare-command and
// shift-down cases. Random add, remove, look-up and spare-command beats then
// follow, drawn mostly from a small key pool and the keys already held. A local
// model predicts each result that the script leaves open. Both channels idle
// and stall in random bursts; the result side holds off for one long stretch.
// ----------------------------------------------------------------------------
module tb_unique_value_set_table_top;

  localparam logic [usvt_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 1350;
  localparam int QUIET_TAIL   = 150;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_t;

  typedef struct packed {
    logic [usvt_pkg::STATUS_W-1:0]    status;
    logic [usvt_pkg::POSITION_W-1:0]  position;
    logic [usvt_pkg::OCCUPANCY_W-1:0] occupancy;
  } outcome_t;

  typedef struct {
    logic [usvt_pkg::CMD_W-1:0] op;
    logic [usvt_pkg::KEY_W-1:0] k;
    bit                         known;
    outcome_t                   want;
  } script_row_t;

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [usvt_pkg::CMD_W-1:0]       cmd;
  logic [usvt_pkg::KEY_W-1:0]       key;
  logic                             out_valid;
  logic                             out_stall;
  logic [usvt_pkg::STATUS_W-1:0]    status;
  logic [usvt_pkg::POSITION_W-1:0]  position;
  logic [usvt_pkg::OCCUPANCY_W-1:0] occupancy;

  logic [usvt_pkg::KEY_W-1:0] held_keys [usvt_pkg::CAPACITY_DEF];
  int                         held_count;
  logic [usvt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  outcome_t                   outcome_q [$];
  script_row_t                script [$];

  int       mismatches;
  int       items_done;
  int       cycles;
  int       stall_left;
  bit       calm;
  bit       hold_long;
  bit       tx_gappy;
  bit       rx_gappy;
  outcome_t rx_want;

  unique_value_set_table_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position),
    .occupancy (occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("ERROR cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // Applies one operation to the local copy of the table and returns its result.
  function automatic outcome_t apply_table_op(input logic [usvt_pkg::CMD_W-1:0] op,
                                              input logic [usvt_pkg::KEY_W-1:0] k);
    outcome_t r;
    int       hit;
    hit = -1;
    for (int i = 0; i < held_count; i++) begin
      if (hit < 0 && held_keys[i] == k) begin
        hit = i;
      end
    end
    r.position = '0;
    case (op)
      usvt_pkg::CMD_ADD: begin
        if (hit >= 0) begin
          r.status = usvt_pkg::STS_DUPLICATE;
          r.position = usvt_pkg::POSITION_W'(hit);
        end else if (held_count >= usvt_pkg::CAPACITY_DEF) begin
          r.status = usvt_pkg::STS_FULL;
        end else begin
          r.status = usvt_pkg::STS_ADDED;
          r.position = usvt_pkg::POSITION_W'(held_count);
          held_keys[held_count] = k;
          held_count++;
        end
      end
      usvt_pkg::CMD_REMOVE: begin
        if (hit < 0) begin
          r.status = usvt_pkg::STS_ABSENT;
        end else begin
          r.status = usvt_pkg::STS_REMOVED;
          r.position = usvt_pkg::POSITION_W'(hit);
          for (int i = hit; i + 1 < held_count; i++) begin
            held_keys[i] = held_keys[i + 1];
          end
          held_count--;
        end
      end
      default: begin
        if (hit >= 0) begin
          r.status = usvt_pkg::STS_FOUND;
          r.position = usvt_pkg::POSITION_W'(hit);
        end else begin
          r.status = usvt_pkg::STS_NOTFOUND;
        end
      end
    endcase
    r.occupancy = usvt_pkg::OCCUPANCY_W'(held_count);
    return r;
  endfunction

  function automatic logic [usvt_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return {$urandom, $urandom};
    end else if (r < 55 && held_count > 0) begin
      return held_keys[$urandom_range(0, held_count - 1)];
    end
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [usvt_pkg::CMD_W-1:0] pick_op(input op_mix_t mix);
    int r;
    int add_lim;
    int rem_lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        add_lim = 60;
        rem_lim = 75;
      end
      MIX_DRAIN: begin
        add_lim = 20;
        rem_lim = 70;
      end
      default: begin
        add_lim = 40;
        rem_lim = 70;
      end
    endcase
    if (r < add_lim) begin
      return usvt_pkg::CMD_ADD;
    end else if (r < rem_lim) begin
      return usvt_pkg::CMD_REMOVE;
    end else if (r < 95) begin
      return usvt_pkg::CMD_LOOKUP;
    end
    return CMD_SPARE;
  endfunction

  task automatic add_row(input logic [usvt_pkg::CMD_W-1:0] op,
                         input logic [usvt_pkg::KEY_W-1:0] k,
                         input bit known, input logic [usvt_pkg::STATUS_W-1:0] st,
                         input int pos, input int occ);
    script_row_t row;
    row.op = op;
    row.k = k;
    row.known = known;
    row.want.status = st;
    row.want.position = usvt_pkg::POSITION_W'(pos);
    row.want.occupancy = usvt_pkg::OCCUPANCY_W'(occ);
    script.push_back(row);
  endtask

  // Offers one input beat and returns at the clock edge that accepts it.
  task automatic offer(input logic [usvt_pkg::CMD_W-1:0] op,
                       input logic [usvt_pkg::KEY_W-1:0] k);
    if (!calm && tx_gappy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    key <= k;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("unique_value_set_table_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (outcome_q.size() == 0) begin
          note_mismatch("result beat with none pending, status", status, 0);
        end else begin
          rx_want = outcome_q.pop_front();
          if (status !== rx_want.status) begin
            note_mismatch("status", status, rx_want.status);
          end
          if (position !== rx_want.position) begin
            note_mismatch("position", position, rx_want.position);
          end
          if (occupancy !== rx_want.occupancy) begin
            note_mismatch("occupancy", occupancy, rx_want.occupancy);
          end
        end
      end
      if ($urandom_range(0, 299) == 0) begin
        rx_gappy = !rx_gappy;
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end else if (!calm && rx_gappy && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      out_stall <= hold_long || stall_left > 0;
    end
  end

  // The result side holds off once for a long stretch so the block backs up.
  initial begin
    hold_long = 1'b0;
    wait (items_done >= 400);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (120) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin
    script_row_t                row;
    outcome_t                   pred;
    op_mix_t                    mix;
    logic [usvt_pkg::CMD_W-1:0] op;
    logic [usvt_pkg::KEY_W-1:0] k;

    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = usvt_pkg::CMD_ADD;
    key = '0;
    out_stall = 1'b0;
    mismatches = 0;
    items_done = 0;
    cycles = 0;
    stall_left = 0;
    calm = 1'b0;
    tx_gappy = 1'b1;
    rx_gappy = 1'b1;
    held_count = 0;
    mix = MIX_FILL;

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = 64'h0000_0000_0000_0001;
    for (int i = 4; i < 14; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end
    for (int i = 14; i < POOL_SIZE; i++) begin
      key_pool[i] = key_pool[i - 10] ^ (64'd1 << $urandom_range(0, usvt_pkg::KEY_W - 1));
    end

    add_row(usvt_pkg::CMD_LOOKUP, '0, 1, usvt_pkg::STS_NOTFOUND, 0, 0);
    add_row(usvt_pkg::CMD_REMOVE, '0, 1, usvt_pkg::STS_ABSENT, 0, 0);
    add_row(usvt_pkg::CMD_ADD, '0, 1, usvt_pkg::STS_ADDED, 0, 1);
    add_row(usvt_pkg::CMD_ADD, '1, 1, usvt_pkg::STS_ADDED, 1, 2);
    add_row(usvt_pkg::CMD_ADD, '0, 1, usvt_pkg::STS_DUPLICATE, 0, 2);
    add_row(CMD_SPARE, '1, 1, usvt_pkg::STS_FOUND, 1, 2);
    add_row(usvt_pkg::CMD_ADD, 64'h8000_0000_0000_0000, 1, usvt_pkg::STS_ADDED, 2, 3);
    add_row(usvt_pkg::CMD_ADD, 64'h0000_0000_0000_0001, 1, usvt_pkg::STS_ADDED, 3, 4);
    for (int i = 0; i < 12; i++) begin
      add_row(usvt_pkg::CMD_ADD, 64'hA5A5_5A5A_0000_0000 + i, 1, usvt_pkg::STS_ADDED,
              i + 4, i + 5);
    end
    add_row(usvt_pkg::CMD_ADD, 64'h5555_5555_5555_5555, 1, usvt_pkg::STS_FULL, 0, 16);
    add_row(usvt_pkg::CMD_ADD, '1, 1, usvt_pkg::STS_DUPLICATE, 1, 16);
    add_row(usvt_pkg::CMD_REMOVE, 64'h8000_0000_0000_0000, 1, usvt_pkg::STS_REMOVED, 2, 15);
    add_row(usvt_pkg::CMD_LOOKUP, 64'h0000_0000_0000_0001, 0, usvt_pkg::STS_FOUND, 0, 0);
    add_row(usvt_pkg::CMD_REMOVE, 64'hA5A5_5A5A_0000_000B, 0, usvt_pkg::STS_REMOVED, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row = script[i];
      offer(row.op, row.k);
      pred = apply_table_op(row.op, row.k);
      outcome_q.push_back(row.known ? row.want : pred);
      items_done++;
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) begin
        mix = op_mix_t'($urandom_range(0, 2));
        tx_gappy = $urandom_range(0, 2) != 0;
      end
      if (n == RANDOM_ITEMS - QUIET_TAIL) begin
        calm <= 1'b1;
      end
      if (n == 900) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0) @(posedge clk);
      end
      op = pick_op(mix);
      k = pick_key();
      offer(op, k);
      outcome_q.push_back(apply_table_op(op, k));
      items_done++;
    end

    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("unique_value_set_table_top: match");
    end else begin
      $display("unique_value_set_table_top: mismatch");
    end
    $finish;
  end

endmodule
